// ===== src/rbd_pkg.sv =====
// Shared types, constants and register codes of the RMS box downscaler.
package rbd_pkg;

  localparam int DEF_MAX_OUT_WIDTH = 256;
  localparam int DEF_MAX_SCALE = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;

  localparam logic [4:0] RST_SCALE = 5'd1;
  localparam logic [12:0] RST_FRAME_WIDTH = 13'd256;
  localparam logic [8:0] RST_OUT_WIDTH = 9'd256;
  localparam logic [8:0] RST_OUT_HEIGHT = 9'd64;

  localparam logic [12:0] FULL_LINE = 13'd4096;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVC,
    ST_DIVR,
    ST_RD,
    ST_ACC,
    ST_DIVS,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [5:0] len;
  } unit_req_t;

endpackage

// ===== src/rbd_if.sv =====
// Handshake interfaces for the pixel, result and configuration channels.
interface rbd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       frame_start;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_start, input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, frame_start, output ready);
endinterface

interface rbd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, row_end, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, row_end, frame_end, output ready);
endinterface

interface rbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rbd_unit.sv =====
// Shared bit-serial divider and square root unit, one quotient or root bit per cycle.
module rbd_unit import rbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  unit_req_t   req,
  input  logic [31:0] num_in,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [9:0]  rem_out
);

  logic        busy;
  op_t         op;
  logic [5:0]  cnt;
  logic [31:0] num;
  logic [19:0] rem;
  logic [19:0] trial;
  logic [19:0] bound;
  logic [20:0] diff;

  always_comb begin
    if (op == OP_SQRT) begin
      trial = {rem[17:0], num[31:30]};
      bound = {quo[17:0], 2'b01};
    end else begin
      trial = {rem[18:0], num[31]};
      bound = {10'd0, divisor};
    end
    diff = {1'b0, trial} - {1'b0, bound};
  end

  assign rem_out = rem[9:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op <= req.op;
        cnt <= req.len;
        num <= num_in;
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        if (diff[20]) begin
          rem <= trial;
          quo <= {quo[30:0], 1'b0};
        end else begin
          rem <= diff[19:0];
          quo <= {quo[30:0], 1'b1};
        end
        num <= (op == OP_SQRT) ? {num[29:0], 2'b00} : {num[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/rms_box_downscaler.sv =====
// Top level of the RMS box downscaler.
//
// Pixels enter in raster order on pix; one downscaled pixel per S-by-S block
// leaves on res, flagged with row_end and frame_end. Registers are written on
// cfg, which is always ready; index 0 is scale, 1 frame_width, 2 out_width,
// 3 out_height.
// The block takes one item at a time. A dropped pixel is only checked, a pixel
// inside a block takes two 12-step divisions of its position, and the last
// pixel of a block takes more on top: for each of three channels
// a 32-step division by S*S and a 16-step square root, all on the single
// shared bit-serial unit.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver still stalls when a new result is ready, the block
// holds it and stays not ready until the output register frees up.
// Reset is synchronous. It restores the register defaults, zeroes the
// position counters and marks every column sum as zero through valid bits,
// so the block is ready in the cycle after reset.
module rms_box_downscaler import rbd_pkg::*; #(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input logic   clk,
  input logic   rst,
  rbd_pix_if.sink   pix,
  rbd_res_if.source res,
  rbd_cfg_if.sink   cfg
);

  localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  logic [4:0]  scale;
  logic [12:0] frame_width;
  logic [8:0]  out_width;
  logic [8:0]  out_height;

  state_t state, state_next;

  logic [11:0] input_column;
  logic [11:0] input_row;
  logic [11:0] col;
  logic [11:0] row;
  logic [7:0]  px_r, px_g, px_b;
  logic [11:0] bx, by;
  logic [9:0]  lx;
  logic [1:0]  chan;
  logic [31:0] sum_r, sum_g, sum_b;
  logic [7:0]  rms_r, rms_g, rms_b;
  logic        last_blk;

  logic [MAX_OUT_WIDTH-1:0] vld;
  logic [95:0] mem [MAX_OUT_WIDTH];
  logic [95:0] rd_data;

  logic [4:0]  s_eff;
  logic [8:0]  ow_eff;
  logic [8:0]  oh_eff;
  logic [12:0] fw_eff;
  logic [13:0] ow_s, oh_s;
  logic [9:0]  ss;
  logic [12:0] col_inc;
  logic [AW-1:0] bx_idx;

  unit_req_t   req;
  logic [31:0] unum;
  logic        udone;
  logic [31:0] uquo;
  logic [9:0]  urem;
  logic [9:0]  divisor_sel;

  logic [31:0] base_r, base_g, base_b;
  logic [31:0] new_r, new_g, new_b;
  logic [31:0] sel_sum;
  logic [7:0]  clamp;
  logic        accept;
  logic        load_out;
  logic        re;

  always_comb begin
    if (scale == 5'd0) s_eff = 5'd1;
    else if (32'(scale) > MAX_SCALE) s_eff = 5'(MAX_SCALE);
    else s_eff = scale;
    if (out_width == 9'd0) ow_eff = 9'd1;
    else if (32'(out_width) > MAX_OUT_WIDTH) ow_eff = 9'(MAX_OUT_WIDTH);
    else ow_eff = out_width;
    oh_eff = (out_height == 9'd0) ? 9'd1 : out_height;
    fw_eff = (frame_width == 13'd0 || frame_width > FULL_LINE) ? FULL_LINE : frame_width;
  end

  assign ow_s = ow_eff * s_eff;
  assign oh_s = oh_eff * s_eff;
  assign ss = s_eff * s_eff;
  assign bx_idx = bx[AW-1:0];
  assign accept = pix.valid && pix.ready;
  assign pix.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= RST_SCALE;
      frame_width <= RST_FRAME_WIDTH;
      out_width <= RST_OUT_WIDTH;
      out_height <= RST_OUT_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCALE: scale <= cfg.data[4:0];
        REG_FRAME_WIDTH: frame_width <= cfg.data;
        REG_OUT_WIDTH: out_width <= cfg.data[8:0];
        REG_OUT_HEIGHT: out_height <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [11:0] c0;
    c0 = pix.frame_start ? 12'd0 : input_column;
    col_inc = {1'b0, c0} + 13'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column <= '0;
      input_row <= '0;
    end else if (accept) begin
      if (col_inc >= fw_eff) begin
        input_column <= '0;
        input_row <= (pix.frame_start ? 12'd0 : input_row) + 12'd1;
      end else begin
        input_column <= col_inc[11:0];
        if (pix.frame_start) input_row <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col <= pix.frame_start ? 12'd0 : input_column;
      row <= pix.frame_start ? 12'd0 : input_row;
      px_r <= pix.pixel_red;
      px_g <= pix.pixel_green;
      px_b <= pix.pixel_blue;
    end
  end

  rbd_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .num_in  (unum),
    .divisor (divisor_sel),
    .done    (udone),
    .quo     (uquo),
    .rem_out (urem)
  );

  assign divisor_sel = (state == ST_CHECK || state == ST_DIVC || state == ST_DIVR) ?
                       {5'd0, s_eff} : ss;

  always_comb begin
    base_r = (lx == 10'd0 && ly_zero) || !vld[bx_idx] ? 32'd0 : rd_data[95:64];
    base_g = (lx == 10'd0 && ly_zero) || !vld[bx_idx] ? 32'd0 : rd_data[63:32];
    base_b = (lx == 10'd0 && ly_zero) || !vld[bx_idx] ? 32'd0 : rd_data[31:0];
    new_r = base_r + {16'd0, 16'(px_r) * 16'(px_r)};
    new_g = base_g + {16'd0, 16'(px_g) * 16'(px_g)};
    new_b = base_b + {16'd0, 16'(px_b) * 16'(px_b)};
    case (chan)
      2'd0: sel_sum = sum_r;
      2'd1: sel_sum = sum_g;
      default: sel_sum = sum_b;
    endcase
    clamp = (|uquo[15:8]) ? 8'd255 : uquo[7:0];
    re = (bx == {3'd0, ow_eff - 9'd1});
  end

  logic ly_zero;

  always_comb begin
    state_next = state;
    req = '{start: 1'b0, op: OP_DIV, len: 6'd0};
    unum = '0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if ({2'd0, col} < ow_s && {2'd0, row} < oh_s) begin
          req = '{start: 1'b1, op: OP_DIV, len: 6'd12};
          unum = {col, 20'd0};
          state_next = ST_DIVC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVC: begin
        if (udone) begin
          req = '{start: 1'b1, op: OP_DIV, len: 6'd12};
          unum = {row, 20'd0};
          state_next = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (udone) state_next = (32'(bx) < MAX_OUT_WIDTH) ? ST_RD : ST_IDLE;
      end
      ST_RD: state_next = ST_ACC;
      ST_ACC: begin
        if (last_blk) begin
          req = '{start: 1'b1, op: OP_DIV, len: 6'd32};
          unum = new_r;
          state_next = ST_DIVS;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVS: begin
        if (udone) begin
          req = '{start: 1'b1, op: OP_SQRT, len: 6'd16};
          unum = uquo;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (udone) begin
          if (chan == 2'd2) begin
            state_next = ST_OUT;
          end else begin
            req = '{start: 1'b1, op: OP_DIV, len: 6'd32};
            unum = (chan == 2'd0) ? sum_g : sum_b;
            state_next = ST_DIVS;
          end
        end
      end
      ST_OUT: begin
        if (!res.valid || res.ready) begin
          load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIVC && udone) begin
      bx <= uquo[11:0];
      lx <= urem;
    end
    if (state == ST_DIVR && udone) begin
      by <= uquo[11:0];
      ly_zero <= (urem == 10'd0);
      last_blk <= (lx == {5'd0, s_eff - 5'd1}) && (urem == {5'd0, s_eff - 5'd1});
    end
    if (state == ST_ACC) begin
      sum_r <= new_r;
      sum_g <= new_g;
      sum_b <= new_b;
      chan <= 2'd0;
    end
    if (state == ST_SQRT && udone) begin
      case (chan)
        2'd0: rms_r <= clamp;
        2'd1: rms_g <= clamp;
        default: rms_b <= clamp;
      endcase
      chan <= chan + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD) rd_data <= mem[bx_idx];
    if (state == ST_ACC) mem[bx_idx] <= {new_r, new_g, new_b};
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (state == ST_ACC) vld[bx_idx] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.out_red <= rms_r;
      res.out_green <= rms_g;
      res.out_blue <= rms_b;
      res.row_end <= re;
      res.frame_end <= re && (by == {3'd0, oh_eff - 9'd1});
    end
  end

endmodule

// ===== src/rbd_check.sv =====
// Port-level assertions for the RMS box downscaler, bound to the top level.
module rbd_check (
  input logic clk,
  input logic rst,
  input logic pix_valid,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input logic row_end,
  input logic frame_end,
  input logic cfg_ready
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("Result dropped while the receiver stalled.");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!frame_end || row_end))
    else $error("Frame end without row end.");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("Block ready right after taking an item.");

  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!pix_ready))
    else $error("Result appeared while the block was idle.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("Configuration channel not ready.");

endmodule

bind rms_box_downscaler rbd_check u_rbd_check (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .row_end   (res.row_end),
  .frame_end (res.frame_end),
  .cfg_ready (cfg.ready)
);
